// ===== hw/rtl/status_led_blink_controller_unit_defines.svh =====
// Assertion macros shared by the status LED blink controller RTL.
`ifndef STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH
`define STATUS_LED_BLINK_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLBC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slbc assertion failed");

`endif

// ===== hw/rtl/slbc_pkg.sv =====
// Shared types and constants for the status LED blink controller.
package slbc_pkg;

    // Default number of status LEDs.
    localparam int LED_COUNT_DEF = 3;

    // Number of channels in the composite pixel.
    localparam int PIXEL_CHANNELS = 3;

    // Command opcodes.
    localparam logic [1:0] OP_ON    = 2'd0;
    localparam logic [1:0] OP_OFF   = 2'd1;
    localparam logic [1:0] OP_BLINK = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ON_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_HALF_PERIOD   = 2'd1;
    localparam logic [1:0] CFG_ONESHOT_DUR   = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  ON_BRIGHTNESS_RST = 8'd10;
    localparam logic [15:0] HALF_PERIOD_RST   = 16'd250;
    localparam logic [15:0] ONESHOT_DUR_RST   = 16'd50;

    // Stream and configuration widths.
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  on_brightness;
        logic [15:0] blink_half_period_ms;
        logic [15:0] oneshot_duration_ms;
    } cfg_t;

    // Composite pixel, first channel in the low byte.
    typedef struct packed {
        logic [7:0] third_level;
        logic [7:0] second_level;
        logic [7:0] first_level;
    } pixel_t;

endpackage

// ===== hw/rtl/slbc_cfg.sv =====
// Configuration register file for the status LED blink controller.
module slbc_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [slbc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [slbc_pkg::CFG_DATA_W-1:0]  wr_data,
    output slbc_pkg::cfg_t                   cfg
);

    slbc_pkg::cfg_t cfg_reg;
    slbc_pkg::cfg_t cfg_next;

    // Decode the register index; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                slbc_pkg::CFG_ON_BRIGHTNESS: cfg_next.on_brightness = wr_data[7:0];
                slbc_pkg::CFG_HALF_PERIOD:   cfg_next.blink_half_period_ms = wr_data;
                slbc_pkg::CFG_ONESHOT_DUR:   cfg_next.oneshot_duration_ms = wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_brightness        <= slbc_pkg::ON_BRIGHTNESS_RST;
            cfg_reg.blink_half_period_ms <= slbc_pkg::HALF_PERIOD_RST;
            cfg_reg.oneshot_duration_ms  <= slbc_pkg::ONESHOT_DUR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/slbc_core.sv =====
// LED state and single-pass command update for the status LED blink controller.
`include "status_led_blink_controller_unit_defines.svh"

module slbc_core
#(
    parameter int LED_COUNT = slbc_pkg::LED_COUNT_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [1:0]       opcode,
    input  logic [1:0]       led_index,
    input  logic             oneshot,
    input  logic [31:0]      now_ms,
    input  slbc_pkg::cfg_t   cfg,
    output logic             res_valid,
    output slbc_pkg::pixel_t res_pixel
);

    localparam int CH = slbc_pkg::PIXEL_CHANNELS;

    logic [LED_COUNT-1:0] lit_reg;
    logic [LED_COUNT-1:0] lit_next;
    logic [LED_COUNT-1:0] blinking_reg;
    logic [LED_COUNT-1:0] blinking_next;
    logic [31:0]          expiry_reg [LED_COUNT];
    logic [31:0]          expiry_next [LED_COUNT];
    logic [31:0]          last_toggle_reg;
    logic [31:0]          last_toggle_next;
    logic                 phase_reg;
    logic                 phase_next;

    logic [LED_COUNT-1:0] sel;
    logic [LED_COUNT-1:0] hit;
    logic [CH+LED_COUNT-1:0] lit_wide;

    // LED select decode for on, off and blink commands.
    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            sel[i] = fire && (opcode != slbc_pkg::OP_TICK)
                     && ({30'd0, led_index} == 32'(i));
        end
    end

    // Next-state logic for one command beat.
    always_comb
    begin
        logic [31:0] arm_time;
        logic [31:0] toggle_at;
        logic        toggle;
        logic        changed;

        lit_next         = lit_reg;
        blinking_next    = blinking_reg;
        expiry_next      = expiry_reg;
        last_toggle_next = last_toggle_reg;
        phase_next       = phase_reg;
        res_valid        = 1'b0;
        changed          = 1'b0;
        hit              = '0;

        arm_time  = now_ms + {16'd0, cfg.oneshot_duration_ms};
        toggle_at = last_toggle_reg + {16'd0, cfg.blink_half_period_ms};
        toggle    = now_ms > toggle_at;

        if (fire && opcode == slbc_pkg::OP_TICK)
        begin
            // Expired one-shot flashes go dark first.
            for (int i = 0; i < LED_COUNT; i++)
            begin
                hit[i] = blinking_reg[i] && (expiry_reg[i] != 32'd0)
                         && (expiry_reg[i] < now_ms);
                if (hit[i])
                begin
                    lit_next[i]      = 1'b0;
                    blinking_next[i] = 1'b0;
                    expiry_next[i]   = 32'd0;
                end
            end
            // Then the shared phase advances and continuous blinkers follow it.
            if (toggle)
            begin
                phase_next       = !phase_reg;
                last_toggle_next = now_ms;
                for (int i = 0; i < LED_COUNT; i++)
                begin
                    if (blinking_next[i] && expiry_next[i] == 32'd0)
                    begin
                        lit_next[i] = !phase_reg;
                        changed     = 1'b1;
                    end
                end
            end
            res_valid = changed || (|hit);
        end
        else
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                if (sel[i])
                begin
                    unique case (opcode) inside
                        slbc_pkg::OP_ON, slbc_pkg::OP_OFF:
                        begin
                            blinking_next[i] = 1'b0;
                            lit_next[i]      = (opcode == slbc_pkg::OP_ON);
                            res_valid        = 1'b1;
                        end
                        slbc_pkg::OP_BLINK:
                        begin
                            blinking_next[i] = 1'b1;
                            if (oneshot)
                            begin
                                expiry_next[i] = arm_time;
                                lit_next[i]    = 1'b1;
                                res_valid      = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // Pixel from the updated lit flags; channels with no LED stay dark.
    assign lit_wide = {{CH{1'b0}}, lit_next};

    always_comb
    begin
        res_pixel.first_level  = lit_wide[0] ? cfg.on_brightness : 8'd0;
        res_pixel.second_level = lit_wide[1] ? cfg.on_brightness : 8'd0;
        res_pixel.third_level  = lit_wide[2] ? cfg.on_brightness : 8'd0;
    end

    // LED and blink state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_reg         <= '0;
            blinking_reg    <= '0;
            last_toggle_reg <= 32'd0;
            phase_reg       <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++)
            begin
                expiry_reg[i] <= 32'd0;
            end
        end
        else
        begin
            lit_reg         <= lit_next;
            blinking_reg    <= blinking_next;
            expiry_reg      <= expiry_next;
            last_toggle_reg <= last_toggle_next;
            phase_reg       <= phase_next;
        end
    end

    // A result only ever comes from a command beat.
    `SLBC_ASSERT_IMP(a_res_needs_fire, !fire, !res_valid)
    // An on command for a present LED leaves at least one LED lit.
    `SLBC_ASSERT_NEXT(a_on_lights, fire && opcode == slbc_pkg::OP_ON && (|sel), |lit_reg)
    // A one-shot arm leaves an LED blinking and lit.
    `SLBC_ASSERT_NEXT(a_oneshot_arms,
        fire && opcode == slbc_pkg::OP_BLINK && oneshot && (|sel),
        (|blinking_reg) && (|lit_reg))

endmodule

// ===== hw/rtl/status_led_blink_controller_unit.sv =====
// A command beat is registered in the input register on acceptance and is processed once the
// output register can take a result; its pixel beat is registered there and presented from it.
// Throughput: one command beat per cycle; a held pixel stalls the input through s_axis_tready.
// Only on, off, one-shot blink and blinker-changing tick commands produce an output beat.
// Reset (rst_n low, asynchronous): all LEDs dark and not blinking, no one-shots armed,
// phase and last toggle time zero, registers at brightness 10, half period 250, duration 50.
`include "status_led_blink_controller_unit_defines.svh"

module status_led_blink_controller_unit
#(
    parameter int LED_COUNT = slbc_pkg::LED_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Command stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: led_index[1:0], oneshot[2], now_ms[34:3], zero pad [39:35].
    input  logic [slbc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [slbc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // Pixel stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: first_level[7:0], second_level[15:8], third_level[23:16].
    output logic [slbc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [slbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [slbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic                               in_valid_reg;
    logic                               in_valid_next;
    logic [slbc_pkg::IN_TDATA_W-1:0]    in_data_reg;
    logic [slbc_pkg::IN_TUSER_W-1:0]    in_user_reg;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    slbc_pkg::pixel_t                   out_pixel_reg;

    logic             out_free;
    logic             fire;
    logic             s_beat;
    logic             res_valid;
    slbc_pkg::pixel_t res_pixel;
    slbc_pkg::cfg_t   cfg;

    // Configuration is always accepted.
    assign cfg_ready = 1'b1;

    slbc_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the held command is processed when the output register can take a result.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_beat)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = fire && res_valid;
        end
    end

    slbc_core #(.LED_COUNT(LED_COUNT)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .opcode    (in_user_reg[1:0]),
        .led_index (in_data_reg[1:0]),
        .oneshot   (in_data_reg[2]),
        .now_ms    (in_data_reg[34:3]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_pixel (res_pixel)
    );

    // Handshake state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
        end
        if (out_free)
        begin
            out_pixel_reg <= res_pixel;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;

    // A held command waits while the output register is blocked.
    `SLBC_ASSERT_NEXT(a_cmd_held, in_valid_reg && !out_free, in_valid_reg)
    // A result beat only follows a processed command.
    `SLBC_ASSERT_NEXT(a_out_from_fire, !out_valid_reg && !fire, !out_valid_reg)
    // A pixel beat stays offered until the receiver takes it.
    `SLBC_ASSERT_NEXT(a_out_held, out_valid_reg && !m_axis_tready, out_valid_reg)

endmodule
